/* rtl/core/sgpg_pkg.sv */
package sgpg_pkg;

  localparam int WORD_ID_BITS = 20;
  localparam int WIN_BITS     = 3;
  localparam int CNT_BITS     = 4;
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  // Register byte addresses
  localparam logic [APB_ADDR_BITS-1:0] ADDR_WINDOW_SIZE = 3'h0;

  typedef struct packed {
    logic [WORD_ID_BITS-1:0] word_id;
    logic                    sentence_end;
  } item_t;

  typedef struct packed {
    logic [WORD_ID_BITS-1:0] center_word;
    logic [WORD_ID_BITS-1:0] context_word;
    logic                    last_of_run;
  } pair_t;

  // Control part of one job handed from the front to the back
  typedef struct packed {
    logic [CNT_BITS-1:0] words_seen;
    logic [WIN_BITS-1:0] window;
    logic                last;
  } job_ctrl_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_FINISH
  } back_state_t;

endpackage

/* rtl/core/sgpg_queue.sv */
module sgpg_queue import sgpg_pkg::*; #(
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  logic [DATA_BITS-1:0] push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output logic [DATA_BITS-1:0] pop_data
);

  logic [DATA_BITS-1:0] entry [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* rtl/core/sgpg_front.sv */
module sgpg_front import sgpg_pkg::*; #(
  parameter int MAX_WINDOW = 5,
  localparam int HIST_DEPTH = 2 * MAX_WINDOW + 1,
  localparam int JOB_BITS = $bits(job_ctrl_t) + HIST_DEPTH * WORD_ID_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  item_t               item,
  input  logic [WIN_BITS-1:0] win_cfg,
  output logic                push_valid,
  input  logic                push_ready,
  output logic [JOB_BITS-1:0] push_data
);

  logic [HIST_DEPTH-1:0][WORD_ID_BITS-1:0] hist;
  logic [HIST_DEPTH-1:0][WORD_ID_BITS-1:0] hist_shift;
  logic [CNT_BITS-1:0]                     words_seen;
  logic [CNT_BITS-1:0]                     seen_inc;
  logic [WIN_BITS-1:0]                     window;
  logic                                    has_work;
  logic                                    accept;
  job_ctrl_t                               ctrl;

  // Newest word at entry 0
  assign hist_shift = {hist[HIST_DEPTH-2:0], item.word_id};
  assign seen_inc   = (words_seen < CNT_BITS'(HIST_DEPTH)) ? words_seen + 1'b1 : words_seen;
  assign window     = (win_cfg > WIN_BITS'(MAX_WINDOW)) ? WIN_BITS'(MAX_WINDOW)
                                                        : win_cfg;

  // A word yields pairs only when a center is ready or the sentence closes
  assign has_work = ({1'b0, window} < seen_inc) || item.sentence_end;

  assign ctrl.words_seen = seen_inc;
  assign ctrl.window     = window;
  assign ctrl.last       = item.sentence_end;

  assign item_ready = push_ready;
  assign accept     = item_valid && item_ready;
  assign push_valid = item_valid && has_work;
  assign push_data  = {ctrl, hist_shift};

  always_ff @(posedge clk) begin
    if (rst) begin
      hist       <= '0;
      words_seen <= '0;
    end else if (accept) begin
      if (item.sentence_end) begin
        hist       <= '0;
        words_seen <= '0;
      end else begin
        hist       <= hist_shift;
        words_seen <= seen_inc;
      end
    end
  end

endmodule

/* rtl/core/sgpg_back.sv */
module sgpg_back import sgpg_pkg::*; #(
  parameter int MAX_WINDOW = 5,
  localparam int HIST_DEPTH = 2 * MAX_WINDOW + 1,
  localparam int JOB_BITS = $bits(job_ctrl_t) + HIST_DEPTH * WORD_ID_BITS,
  localparam int OFF_BITS = $clog2(HIST_DEPTH),
  localparam int CTR_BITS = $clog2(MAX_WINDOW + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  logic [JOB_BITS-1:0] pop_data,
  output logic                pair_valid,
  input  logic                pair_ready,
  output pair_t               pair
);

  logic [HIST_DEPTH-1:0][WORD_ID_BITS-1:0] job_hist;
  job_ctrl_t                               job_ctrl;

  back_state_t                             state;
  back_state_t                             state_next;
  logic [HIST_DEPTH-1:0][WORD_ID_BITS-1:0] hist;
  job_ctrl_t                               ctrl;
  logic [CTR_BITS-1:0]                     center;
  logic [CTR_BITS-1:0]                     center_next;
  logic [OFF_BITS-1:0]                     off;
  logic [OFF_BITS-1:0]                     off_next;
  logic                                    pend_valid;
  logic                                    pend_valid_next;
  pair_t                                   pend;
  pair_t                                   pend_next;
  logic                                    out_load;
  pair_t                                   out_next;
  logic                                    load_job;

  logic [CNT_BITS-1:0]     job_seen_m1;
  logic [CTR_BITS-1:0]     job_win;
  logic                    win_below;
  logic                    start_ok;
  logic [CTR_BITS-1:0]     first_center;
  logic [OFF_BITS-1:0]     first_sum;
  logic [OFF_BITS-1:0]     first_lim;
  logic [OFF_BITS-1:0]     first_hi;

  logic [CTR_BITS-1:0]     win;
  logic [CNT_BITS-1:0]     seen_m1;
  logic [CTR_BITS-1:0]     center_dec;
  logic [OFF_BITS-1:0]     dec_sum;
  logic [OFF_BITS-1:0]     dec_lim;
  logic [OFF_BITS-1:0]     dec_hi;

  logic [WORD_ID_BITS-1:0] ctx_word;
  logic [WORD_ID_BITS-1:0] ctr_word;
  logic                    produce;
  logic                    out_free;
  logic                    stall;

  assign {job_ctrl, job_hist} = pop_data;

  // First center of a job: the one that just got its full right context,
  // or on a sentence end with too few words, the oldest word held.
  assign job_seen_m1  = job_ctrl.words_seen - 1'b1;
  assign job_win      = CTR_BITS'(job_ctrl.window);
  assign win_below    = ({1'b0, job_ctrl.window} < job_ctrl.words_seen);
  assign start_ok     = win_below || job_ctrl.last;
  assign first_center = win_below ? job_win : CTR_BITS'(job_seen_m1);
  assign first_sum    = OFF_BITS'(first_center) + OFF_BITS'(job_win);
  assign first_lim    = OFF_BITS'(job_seen_m1);
  assign first_hi     = (first_sum < first_lim) ? first_sum : first_lim;

  // Next younger center during a flush
  assign win        = CTR_BITS'(ctrl.window);
  assign seen_m1    = ctrl.words_seen - 1'b1;
  assign center_dec = center - 1'b1;
  assign dec_sum    = OFF_BITS'(center_dec) + OFF_BITS'(win);
  assign dec_lim    = OFF_BITS'(seen_m1);
  assign dec_hi     = (dec_sum < dec_lim) ? dec_sum : dec_lim;

  // One context position per cycle unless a pair waits on a stalled output; equal ids are dropped
  assign ctx_word = hist[off];
  assign ctr_word = hist[OFF_BITS'(center)];
  assign produce  = (ctx_word != ctr_word);
  assign out_free = !pair_valid || pair_ready;
  assign stall    = produce && pend_valid && !out_free;

  assign pop_ready = (state == BK_IDLE);

  always_comb begin
    state_next      = state;
    center_next     = center;
    off_next        = off;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    out_load        = 1'b0;
    out_next        = '{center_word: pend.center_word, context_word: pend.context_word,
                        last_of_run: 1'b0};
    load_job        = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (pop_valid) begin
          load_job = 1'b1;
          if (start_ok) begin
            state_next  = BK_RUN;
            center_next = first_center;
            off_next    = first_hi;
          end
        end
      end
      BK_RUN: begin
        if (!stall) begin
          if (produce) begin
            // Hold one pair back so the final pair can carry last_of_run
            out_load        = pend_valid;
            pend_valid_next = 1'b1;
            pend_next       = '{center_word: ctr_word, context_word: ctx_word,
                                last_of_run: 1'b0};
          end
          if (off != '0) begin
            off_next = off - 1'b1;
          end else if (ctrl.last && center != '0) begin
            center_next = center_dec;
            off_next    = dec_hi;
          end else begin
            state_next = BK_FINISH;
          end
        end
      end
      BK_FINISH: begin
        if (!pend_valid) begin
          state_next = BK_IDLE;
        end else if (out_free) begin
          out_load             = 1'b1;
          out_next.last_of_run = 1'b1;
          pend_valid_next      = 1'b0;
          state_next           = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      pend_valid <= 1'b0;
      pair_valid <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= pend_valid_next;
      if (out_load) begin
        pair_valid <= 1'b1;
      end else if (pair_ready) begin
        pair_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    center <= center_next;
    off    <= off_next;
    pend   <= pend_next;
    if (out_load) begin
      pair <= out_next;
    end
    if (load_job) begin
      hist <= job_hist;
      ctrl <= job_ctrl;
    end
  end

endmodule

/* rtl/core/skip_gram_pair_generator.sv */
// Skip-gram pair generator.
// Feed one word per handshake on the item channel (word_id, sentence_end);
// (center, context) pairs come out one per handshake on the pair channel,
// context positions in sentence order, ids equal to the center dropped.
// A center leaves once the window's worth of later words arrived; a
// sentence-end word flushes every remaining center and clears the history.
// Program the window register over the APB port at address 0 while the block
// is idle; values above MAX_WINDOW act as MAX_WINDOW.
// The back sequencer scans one context position per cycle, unless a pair must
// wait on a stalled output register. A two-entry job queue lets the front take
// up to two more pair-producing words meanwhile.
// Reset: the window register returns to 5, the history and the queue empty out.
// Receiver stall: the output register holds its word; the back halts on the
// next pair, the queue fills, then item_ready drops.
module skip_gram_pair_generator import sgpg_pkg::*; #(
  parameter int MAX_WINDOW = 5
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_ready,
  input  item_t                    item,
  output logic                     pair_valid,
  input  logic                     pair_ready,
  output pair_t                    pair,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int HIST_DEPTH = 2 * MAX_WINDOW + 1;
  localparam int JOB_BITS   = $bits(job_ctrl_t) + HIST_DEPTH * WORD_ID_BITS;

  logic [WIN_BITS-1:0] win_cfg;
  logic                push_valid;
  logic                push_ready;
  logic [JOB_BITS-1:0] push_data;
  logic                pop_valid;
  logic                pop_ready;
  logic [JOB_BITS-1:0] pop_data;
  logic                cfg_write;

  // Config port: zero wait states, one register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[APB_ADDR_BITS-1:2] ==
                     ADDR_WINDOW_SIZE[APB_ADDR_BITS-1:2]);
  assign prdata    = (paddr[APB_ADDR_BITS-1:2] == ADDR_WINDOW_SIZE[APB_ADDR_BITS-1:2])
                     ? APB_DATA_BITS'(win_cfg) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_cfg <= WIN_BITS'(5);
    end else if (cfg_write) begin
      win_cfg <= pwdata[WIN_BITS-1:0];
    end
  end

  // Front: advance the history, snapshot it into a job
  sgpg_front #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .win_cfg    (win_cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decouple front and back
  sgpg_queue #(
    .DATA_BITS (JOB_BITS)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: walk centers and contexts, drive the pair register
  sgpg_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .pair_valid (pair_valid),
    .pair_ready (pair_ready),
    .pair       (pair)
  );

endmodule

/* dv/skip_gram_pair_checker.sv */
`timescale 1ns / 1ps

module skip_gram_pair_checker import sgpg_pkg::*; #(
  parameter int MAX_WINDOW = 5
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  input  logic                     item_ready,
  input  item_t                    item,
  input  logic                     pair_valid,
  input  logic                     pair_ready,
  input  pair_t                    pair,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic                     pready,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  input  logic [APB_DATA_BITS-1:0] prdata,
  output int                       error_count,
  output int                       pending_pairs,
  output int                       words_taken,
  output int                       pairs_matched
);

  localparam int DEPTH = 2 * MAX_WINDOW + 1;

  logic [WORD_ID_BITS-1:0] history [DEPTH];
  int                      seen_count;
  logic [WIN_BITS-1:0]     window;
  pair_t                   expected_pairs [$];

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Queue the pairs of the center at history offset c, oldest context first.
  function automatic void push_center_pairs(input int c, input int w);
    int    hi;
    int    lo;
    pair_t p;
    hi = c + w;
    lo = (c >= w) ? c - w : 0;
    if (hi > seen_count - 1) hi = seen_count - 1;
    for (int off = hi; off >= lo; off--) begin
      if (history[off] != history[c]) begin
        p.center_word  = history[c];
        p.context_word = history[off];
        p.last_of_run  = 1'b0;
        expected_pairs.insert(expected_pairs.size(), p);
      end
    end
  endfunction

  function automatic void predict_pairs(input item_t w_in);
    int    win;
    int    base_count;
    pair_t tail;
    win = (window > MAX_WINDOW) ? MAX_WINDOW : int'(window);
    base_count = expected_pairs.size();
    for (int i = DEPTH - 1; i > 0; i--) history[i] = history[i - 1];
    history[0] = w_in.word_id;
    if (seen_count < DEPTH) seen_count++;
    if (win < seen_count) push_center_pairs(win, win);
    if (w_in.sentence_end) begin
      for (int c = win - 1; c >= 0; c--) begin
        if (c < seen_count) push_center_pairs(c, win);
      end
      foreach (history[i]) history[i] = '0;
      seen_count = 0;
    end
    // flag the final pair of this word
    if (expected_pairs.size() > base_count) begin
      tail = expected_pairs[expected_pairs.size() - 1];
      tail.last_of_run = 1'b1;
      expected_pairs[expected_pairs.size() - 1] = tail;
    end
  endfunction

  always @(posedge clk) begin
    pair_t want;
    if (rst) begin
      foreach (history[i]) history[i] = '0;
      seen_count = 0;
      window = WIN_BITS'(5);
      expected_pairs.delete();
      error_count = 0;
      words_taken = 0;
      pairs_matched = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == ADDR_WINDOW_SIZE) window = pwdata[WIN_BITS-1:0];
        end else if (paddr == ADDR_WINDOW_SIZE &&
                     prdata !== APB_DATA_BITS'(window)) begin
          report_mismatch($sformatf("window read %0h, expected %0h", prdata, window));
        end
      end
      if (pair_valid && pair_ready) begin
        if (expected_pairs.size() == 0) begin
          report_mismatch($sformatf("unexpected pair center=%0h context=%0h last=%0b",
                                    pair.center_word, pair.context_word, pair.last_of_run));
        end else begin
          want = expected_pairs.pop_front();
          if (pair.center_word !== want.center_word ||
              pair.context_word !== want.context_word ||
              pair.last_of_run !== want.last_of_run) begin
            report_mismatch($sformatf(
              "pair center=%0h context=%0h last=%0b, expected %0h %0h %0b",
              pair.center_word, pair.context_word, pair.last_of_run,
              want.center_word, want.context_word, want.last_of_run));
          end else begin
            pairs_matched++;
          end
        end
      end
      if (item_valid && item_ready) begin
        predict_pairs(item);
        words_taken++;
      end
    end
    pending_pairs = expected_pairs.size();
  end

endmodule

/* dv/skip_gram_pair_generator_tb.sv */
`timescale 1ns / 1ps

module skip_gram_pair_generator_tb;
  import sgpg_pkg::*;

  localparam int MAX_WINDOW   = 5;
  localparam int CYCLE_LIMIT  = 1_000_000;
  // allow for three jobs of the worst sentence-end flush
  localparam int QUIET_CYCLES = 250;
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_WORDS  = 56;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     item_valid = 1'b0;
  logic                     item_ready;
  item_t                    item = '0;
  logic                     pair_valid;
  logic                     pair_ready = 1'b0;
  pair_t                    pair;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  int error_count;
  int pending_pairs;
  int words_taken;
  int pairs_matched;
  int cycle_count = 0;

  // sender and receiver knobs, set per phase by the stimulus process
  rx_mode_t    rx_mode = RX_ALWAYS;
  logic [15:0] rx_pattern = 16'b1011_0011_1000_1111;
  bit          long_hold_req = 1'b0;
  bit          long_hold_done = 1'b0;
  bit          gaps_on = 1'b1;
  int          burst_left = 0;
  int          sentence_left = 0;

  skip_gram_pair_generator #(.MAX_WINDOW(MAX_WINDOW)) u_dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .pair_valid (pair_valid),
    .pair_ready (pair_ready),
    .pair       (pair),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  skip_gram_pair_checker #(.MAX_WINDOW(MAX_WINDOW)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .pair_valid    (pair_valid),
    .pair_ready    (pair_ready),
    .pair          (pair),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .error_count   (error_count),
    .pending_pairs (pending_pairs),
    .words_taken   (words_taken),
    .pairs_matched (pairs_matched)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Bail out if the run hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Cycle limit of %0d reached with %0d pairs pending", CYCLE_LIMIT, pending_pairs);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: stall on its own schedule. Hold off once for a long stretch
  // when asked, so the job queue fills and item_ready drops.
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold_req && !long_hold_done) begin
        pair_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_done = 1'b1;
      end else begin
        case (rx_mode)
          RX_ALWAYS: pair_ready <= 1'b1;
          RX_RANDOM: pair_ready <= ($urandom_range(0, 3) != 0);
          default: begin
            pair_ready <= rx_pattern[0];
            rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
          end
        endcase
      end
    end
  end

  // Offer one item word and hold it until taken. Insert a random gap
  // between bursts when gaps are enabled.
  task automatic send_word(input logic [WORD_ID_BITS-1:0] id, input logic last_word);
    item_t next;
    next.word_id = id;
    next.sentence_end = last_word;
    if (burst_left == 0) begin
      if (gaps_on) begin
        @(negedge clk);
        item_valid <= 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    item_valid <= 1'b1;
    item <= next;
    do @(posedge clk); while (!item_ready);
  endtask

  // Drop valid and wait until every predicted pair has come out.
  task automatic drain_pairs();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_pairs != 0) @(negedge clk);
  endtask

  // Wait out jobs that still run but produce no pairs.
  task automatic settle_idle();
    drain_pairs();
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input logic [APB_ADDR_BITS-1:0] addr,
                           input logic [APB_DATA_BITS-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // The checker compares prdata during the access phase.
  task automatic apb_read(input logic [APB_ADDR_BITS-1:0] addr);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_window(input logic [WIN_BITS-1:0] w);
    settle_idle();
    apb_write(ADDR_WINDOW_SIZE, APB_DATA_BITS'(w));
    apb_read(ADDR_WINDOW_SIZE);
  endtask

  // Mix a tiny vocabulary (forces skipped repeats), extremes and full-range ids.
  function automatic logic [WORD_ID_BITS-1:0] pick_word_id();
    case ($urandom_range(0, 7))
      0, 1, 2: pick_word_id = WORD_ID_BITS'($urandom_range(0, 5));
      3:       pick_word_id = $urandom_range(0, 1) ? '1 : '0;
      default: pick_word_id = WORD_ID_BITS'($urandom);
    endcase
  endfunction

  // Mostly short sentences, a few long enough to saturate the history.
  function automatic int pick_sentence_len();
    case ($urandom_range(0, 9))
      0:       pick_sentence_len = 1;
      7, 8:    pick_sentence_len = $urandom_range(13, 24);
      9:       pick_sentence_len = $urandom_range(25, 40);
      default: pick_sentence_len = $urandom_range(2, 12);
    endcase
  endfunction

  // Stream words; a sentence cut at the phase boundary continues under the
  // next window setting.
  task automatic send_sentences(input int n);
    for (int i = 0; i < n; i++) begin
      if (sentence_left == 0) sentence_left = pick_sentence_len();
      sentence_left--;
      send_word(pick_word_id(), sentence_left == 0);
      // pause now and then until the block has emptied out
      if ($urandom_range(0, 59) == 0) drain_pairs();
    end
  endtask

  initial begin
    logic [WIN_BITS-1:0] phase_windows [8];
    phase_windows = '{3'd1, 3'd7, 3'd3, 3'd0, 3'd5, 3'd2, 3'd6, 3'd4};

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset window of 5.
    apb_read(ADDR_WINDOW_SIZE);
    gaps_on = 1'b0;
    send_word('1, 1'b1);                       // lone word: no pairs
    send_word('0, 1'b0);                       // extremes and repeats
    send_word('1, 1'b0);
    send_word('0, 1'b0);
    send_word(20'h00007, 1'b0);
    send_word(20'h00007, 1'b0);
    send_word('1, 1'b1);
    for (int i = 0; i < 11; i++) begin         // distinct words fill the history
      send_word(WORD_ID_BITS'(20'h80000 >> i), i == 10);
    end
    set_window(3'd0);                          // window zero: nothing comes out
    send_word(20'h00005, 1'b0);
    send_word(20'h00006, 1'b0);
    send_word(20'h00005, 1'b1);
    set_window(3'd2);                          // window 2; the next change lands mid-sentence
    for (int i = 0; i < 4; i++) send_word(WORD_ID_BITS'(20'h12340 + i), 1'b0);
    set_window(3'd4);
    send_word(20'h12340, 1'b0);
    send_word(20'hABCDE, 1'b1);

    // Random phases across window settings, receiver modes and gap styles.
    for (int ph = 0; ph < 8; ph++) begin
      set_window(phase_windows[ph]);
      rx_mode = rx_mode_t'(ph % 3);
      rx_pattern = 16'($urandom) | 16'h0001;
      gaps_on = (ph % 4 != 1);
      if (phase_windows[ph] == 3'd5) begin
        // back-pressure phase: stream without gaps into a stalled receiver
        gaps_on = 1'b0;
        long_hold_req = 1'b1;
      end
      send_sentences(PHASE_WORDS);
      long_hold_req = 1'b0;
    end

    settle_idle();
    $display("Checked %0d pairs from %0d words over window sizes 0 to 7,",
             pairs_matched, words_taken);
    $display("with sentences cut across window changes and a long output stall.");
    if (error_count == 0 && pending_pairs == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/sgpg_pkg.sv
rtl/core/sgpg_queue.sv
rtl/core/sgpg_front.sv
rtl/core/sgpg_back.sv
rtl/core/skip_gram_pair_generator.sv
dv/skip_gram_pair_checker.sv
dv/skip_gram_pair_generator_tb.sv
